// File: hdl/lru_key_value_cache_defines.svh
// Assertion macros for the LRU key-value cache.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef SYNTHESIS

`define LRC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrc assertion failed");

`define LRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrc assertion failed");

`else

`define LRC_ASSERT_IMPL(label, ante, cons)

`define LRC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hdl/lrc_pkg.sv
// Shared constants, codes and control structs of the LRU key-value cache.
`default_nettype none

package lrc_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 32;
    localparam int HANDLE_W = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int AGE_W    = IDX_W;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int STAT_W   = 32;
    localparam int MAXE_W   = 5;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [MAXE_W-1:0]  MAXE_RESET = MAXE_W'(CAPACITY);
    localparam logic [PADDR_W-1:0] ADDR_MAX_ENTRIES = 3'd0;

    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RSTCNT = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NULL     = 2'd2;

    // command to the entry store for one cycle
    typedef struct packed {
        logic [IDX_W-1:0] idx;        // scan pointer: read port and age update slot
        logic             age_en;
        logic             age_drop;   // 0: touch (younger +1, target 0), 1: older -1
        logic [CNT_W-1:0] age_ref;
        logic [IDX_W-1:0] age_tgt;
        logic             inval_en;
        logic [IDX_W-1:0] inval_slot;
        logic             fill_en;    // new entry: valid, key, handle
        logic             hdl_en;     // handle rewrite only
        logic [IDX_W-1:0] wr_slot;
        logic             clear_all;
    } lrc_store_cmd_t;

    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [HANDLE_W-1:0] handle;
        logic [AGE_W-1:0]    age;
    } lrc_store_rd_t;

    typedef struct packed {
        logic inc_hit;
        logic inc_miss;
        logic inc_evict;
        logic clear;
    } lrc_stats_cmd_t;

endpackage

`default_nettype wire

// File: hdl/lrc_store.sv
// Entry store: keys, handles, ages and valid bits, with the shared age update unit.
`default_nettype none

module lrc_store (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lrc_pkg::lrc_store_cmd_t        cmd,
    input  wire logic [lrc_pkg::KEY_BITS-1:0]   wr_key,
    input  wire logic [lrc_pkg::HANDLE_W-1:0]   wr_handle,
    output lrc_pkg::lrc_store_rd_t              rd,
    output logic [lrc_pkg::CAPACITY-1:0]        valid_vec
);
    import lrc_pkg::*;

    logic [KEY_BITS-1:0] key_reg    [CAPACITY];
    logic [HANDLE_W-1:0] handle_reg [CAPACITY];
    logic [AGE_W-1:0]    age_reg    [CAPACITY];
    logic [CAPACITY-1:0] valid_reg;
    logic [AGE_W-1:0]    age_next;
    logic                age_wr;

    assign rd.valid   = valid_reg[cmd.idx];
    assign rd.key     = key_reg[cmd.idx];
    assign rd.handle  = handle_reg[cmd.idx];
    assign rd.age     = age_reg[cmd.idx];
    assign valid_vec  = valid_reg;

    // one age step per cycle at the scan pointer
    always_comb
    begin
        age_next = rd.age;
        age_wr   = 1'b0;
        if (cmd.age_en && rd.valid)
        begin
            if (!cmd.age_drop)
            begin
                if (cmd.idx == cmd.age_tgt)
                begin
                    age_next = '0;
                    age_wr   = 1'b1;
                end
                else if ({1'b0, rd.age} < cmd.age_ref)
                begin
                    age_next = rd.age + AGE_W'(1);
                    age_wr   = 1'b1;
                end
            end
            else if ({1'b0, rd.age} > cmd.age_ref)
            begin
                age_next = rd.age - AGE_W'(1);
                age_wr   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.clear_all)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (cmd.inval_en)
            begin
                valid_reg[cmd.inval_slot] <= 1'b0;
            end
            if (cmd.fill_en)
            begin
                valid_reg[cmd.wr_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_en)
        begin
            key_reg[cmd.wr_slot] <= wr_key;
        end
        if (cmd.fill_en || cmd.hdl_en)
        begin
            handle_reg[cmd.wr_slot] <= wr_handle;
        end
        if (age_wr)
        begin
            age_reg[cmd.idx] <= age_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lrc_stats.sv
// Saturating hit, miss and eviction counters.
`default_nettype none

module lrc_stats (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire lrc_pkg::lrc_stats_cmd_t      cmd,
    output logic [lrc_pkg::STAT_W-1:0]        hits,
    output logic [lrc_pkg::STAT_W-1:0]        misses,
    output logic [lrc_pkg::STAT_W-1:0]        evictions
);
    import lrc_pkg::*;

    logic [STAT_W-1:0] hit_reg, hit_next;
    logic [STAT_W-1:0] miss_reg, miss_next;
    logic [STAT_W-1:0] evict_reg, evict_next;

    always_comb
    begin
        hit_next   = hit_reg;
        miss_next  = miss_reg;
        evict_next = evict_reg;
        if (cmd.clear)
        begin
            hit_next   = '0;
            miss_next  = '0;
            evict_next = '0;
        end
        else
        begin
            if (cmd.inc_hit && (hit_reg != '1))
            begin
                hit_next = hit_reg + STAT_W'(1);
            end
            if (cmd.inc_miss && (miss_reg != '1))
            begin
                miss_next = miss_reg + STAT_W'(1);
            end
            if (cmd.inc_evict && (evict_reg != '1))
            begin
                evict_next = evict_reg + STAT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= '0;
            miss_reg  <= '0;
            evict_reg <= '0;
        end
        else
        begin
            hit_reg   <= hit_next;
            miss_reg  <= miss_next;
            evict_reg <= evict_next;
        end
    end

    assign hits      = hit_reg;
    assign misses    = miss_reg;
    assign evictions = evict_reg;

endmodule

`default_nettype wire

// File: hdl/lru_key_value_cache.sv
// Flow: a word is scanned against every entry, decided, then, when an entry is touched,
// filled or removed, passed through an age-update pass before the result is registered.
// The single entry scan pointer serves both passes, so a new word is taken only after that.
// The next word is taken while the result word still waits to be taken.
// Reset clears valid bits, occupancy and counters, sets max_entries to 16;
// no clearing pass is needed.
`default_nettype none

`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [lrc_pkg::ACTION_W-1:0]    action,
    input  wire logic [lrc_pkg::KEY_BITS-1:0]    key,
    input  wire logic [lrc_pkg::HANDLE_W-1:0]    handle,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [lrc_pkg::STATUS_W-1:0]         status,
    output logic [lrc_pkg::HANDLE_W-1:0]         handle_out,
    output logic                                 evicted,
    output logic [lrc_pkg::KEY_BITS-1:0]         evicted_key,
    output logic [lrc_pkg::CNT_W-1:0]            occupancy,
    output logic [lrc_pkg::STAT_W-1:0]           hits,
    output logic [lrc_pkg::STAT_W-1:0]           misses,
    output logic [lrc_pkg::STAT_W-1:0]           evictions,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lrc_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [lrc_pkg::PDATA_W-1:0]     pwdata,
    output logic [lrc_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready
);
    import lrc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_AGE    = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [HANDLE_W-1:0] hdl_reg, hdl_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [MAXE_W-1:0]   maxe_reg;

    logic                match_found_reg, match_found_next;
    logic [IDX_W-1:0]    match_slot_reg, match_slot_next;
    logic [AGE_W-1:0]    match_age_reg, match_age_next;
    logic [HANDLE_W-1:0] match_hdl_reg, match_hdl_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_slot_reg, free_slot_next;
    logic                old_found_reg, old_found_next;
    logic [IDX_W-1:0]    old_slot_reg, old_slot_next;
    logic [AGE_W-1:0]    old_age_reg, old_age_next;
    logic [KEY_BITS-1:0] old_key_reg, old_key_next;

    logic                age_drop_reg, age_drop_next;
    logic [CNT_W-1:0]    age_ref_reg, age_ref_next;
    logic [IDX_W-1:0]    age_tgt_reg, age_tgt_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [HANDLE_W-1:0] res_hdl_reg, res_hdl_next;
    logic                res_ev_reg, res_ev_next;
    logic [KEY_BITS-1:0] res_evk_reg, res_evk_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [HANDLE_W-1:0] out_hdl_reg;
    logic                out_ev_reg;
    logic [KEY_BITS-1:0] out_evk_reg;
    logic [CNT_W-1:0]    out_occ_reg;
    logic [STAT_W-1:0]   out_hits_reg, out_misses_reg, out_evictions_reg;
    logic                out_load;

    lrc_store_cmd_t      scmd;
    lrc_store_rd_t       srd;
    logic [CAPACITY-1:0] valid_vec;
    lrc_stats_cmd_t      tcmd;
    logic [STAT_W-1:0]   st_hits, st_misses, st_evictions;

    logic [CNT_W-1:0]    limit;
    logic                scan_last;
    logic                do_evict;
    logic [IDX_W-1:0]    new_slot;
    logic                cfg_wr;

    lrc_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (scmd),
        .wr_key    (key_reg),
        .wr_handle (hdl_reg),
        .rd        (srd),
        .valid_vec (valid_vec)
    );

    lrc_stats u_stats (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (tcmd),
        .hits      (st_hits),
        .misses    (st_misses),
        .evictions (st_evictions)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_MAX_ENTRIES);
    assign prdata = (paddr == ADDR_MAX_ENTRIES) ? PDATA_W'(maxe_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxe_reg <= MAXE_RESET;
        end
        else if (cfg_wr)
        begin
            maxe_reg <= pwdata[MAXE_W-1:0];
        end
    end

    // limit clamped to 1..CAPACITY
    always_comb
    begin
        if (maxe_reg == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (CNT_W'(maxe_reg) > CNT_W'(CAPACITY))
        begin
            limit = CNT_W'(CAPACITY);
        end
        else
        begin
            limit = CNT_W'(maxe_reg);
        end
    end

    assign scan_last = (idx_reg == IDX_W'(CAPACITY - 1));
    assign do_evict  = (count_reg >= limit) && old_found_reg;
    // after an eviction the lowest free slot is the victim or a lower free one
    assign new_slot  = (do_evict && !(free_found_reg && (free_slot_reg < old_slot_reg)))
                       ? old_slot_reg : free_slot_reg;

    assign in_stall = (state_reg != S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        act_next         = act_reg;
        key_next         = key_reg;
        hdl_next         = hdl_reg;
        count_next       = count_reg;
        match_found_next = match_found_reg;
        match_slot_next  = match_slot_reg;
        match_age_next   = match_age_reg;
        match_hdl_next   = match_hdl_reg;
        free_found_next  = free_found_reg;
        free_slot_next   = free_slot_reg;
        old_found_next   = old_found_reg;
        old_slot_next    = old_slot_reg;
        old_age_next     = old_age_reg;
        old_key_next     = old_key_reg;
        age_drop_next    = age_drop_reg;
        age_ref_next     = age_ref_reg;
        age_tgt_next     = age_tgt_reg;
        res_status_next  = res_status_reg;
        res_hdl_next     = res_hdl_reg;
        res_ev_next      = res_ev_reg;
        res_evk_next     = res_evk_reg;
        out_valid_next   = out_valid_reg && out_stall;

        scmd             = '0;
        scmd.idx         = idx_reg;
        scmd.age_drop    = age_drop_reg;
        scmd.age_ref     = age_ref_reg;
        scmd.age_tgt     = age_tgt_reg;
        tcmd             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next         = action;
                    key_next         = key;
                    hdl_next         = handle;
                    idx_next         = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    old_found_next   = 1'b0;
                    state_next       = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (!match_found_reg && srd.valid && (srd.key == key_reg))
                begin
                    match_found_next = 1'b1;
                    match_slot_next  = idx_reg;
                    match_age_next   = srd.age;
                    match_hdl_next   = srd.handle;
                end
                if (!free_found_reg && !srd.valid)
                begin
                    free_found_next = 1'b1;
                    free_slot_next  = idx_reg;
                end
                if (srd.valid && (!old_found_reg || (srd.age > old_age_reg)))
                begin
                    old_found_next = 1'b1;
                    old_slot_next  = idx_reg;
                    old_age_next   = srd.age;
                    old_key_next   = srd.key;
                end
                if (scan_last)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_DECIDE:
            begin
                res_status_next = ST_OK;
                res_hdl_next    = '0;
                res_ev_next     = 1'b0;
                res_evk_next    = '0;
                idx_next        = '0;
                state_next      = S_DONE;
                age_drop_next   = 1'b0;
                age_tgt_next    = match_slot_reg;
                age_ref_next    = CNT_W'(match_age_reg);
                unique case (act_reg)
                    ACT_LOOKUP:
                    begin
                        if (match_found_reg)
                        begin
                            res_hdl_next = match_hdl_reg;
                            tcmd.inc_hit = 1'b1;
                            state_next   = S_AGE;
                        end
                        else
                        begin
                            res_status_next = ST_NOTFOUND;
                            tcmd.inc_miss   = 1'b1;
                        end
                    end
                    ACT_INSERT:
                    begin
                        if (hdl_reg == '0)
                        begin
                            res_status_next = ST_NULL;
                        end
                        else if (match_found_reg)
                        begin
                            scmd.hdl_en  = 1'b1;
                            scmd.wr_slot = match_slot_reg;
                            state_next   = S_AGE;
                        end
                        else
                        begin
                            if (do_evict)
                            begin
                                scmd.inval_en   = 1'b1;
                                scmd.inval_slot = old_slot_reg;
                                res_ev_next     = 1'b1;
                                res_evk_next    = old_key_reg;
                                tcmd.inc_evict  = 1'b1;
                            end
                            if (do_evict || free_found_reg)
                            begin
                                // new entry: every other valid entry ages by one
                                scmd.fill_en  = 1'b1;
                                scmd.wr_slot  = new_slot;
                                age_tgt_next  = new_slot;
                                age_ref_next  = CNT_W'(CAPACITY);
                                state_next    = S_AGE;
                                if (!do_evict)
                                begin
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (match_found_reg)
                        begin
                            scmd.inval_en   = 1'b1;
                            scmd.inval_slot = match_slot_reg;
                            age_drop_next   = 1'b1;
                            state_next      = S_AGE;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        else
                        begin
                            res_status_next = ST_NOTFOUND;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        scmd.clear_all = 1'b1;
                        count_next     = '0;
                    end
                    ACT_RSTCNT:
                    begin
                        tcmd.clear = 1'b1;
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end

            S_AGE:
            begin
                scmd.age_en = 1'b1;
                if (scan_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // flags are set up at accept, so they need no reset
    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        key_reg         <= key_next;
        hdl_reg         <= hdl_next;
        match_found_reg <= match_found_next;
        match_slot_reg  <= match_slot_next;
        match_age_reg   <= match_age_next;
        match_hdl_reg   <= match_hdl_next;
        free_found_reg  <= free_found_next;
        free_slot_reg   <= free_slot_next;
        old_found_reg   <= old_found_next;
        old_slot_reg    <= old_slot_next;
        old_age_reg     <= old_age_next;
        old_key_reg     <= old_key_next;
        age_drop_reg    <= age_drop_next;
        age_ref_reg     <= age_ref_next;
        age_tgt_reg     <= age_tgt_next;
        res_status_reg  <= res_status_next;
        res_hdl_reg     <= res_hdl_next;
        res_ev_reg      <= res_ev_next;
        res_evk_reg     <= res_evk_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg    <= res_status_reg;
            out_hdl_reg       <= res_hdl_reg;
            out_ev_reg        <= res_ev_reg;
            out_evk_reg       <= res_evk_reg;
            out_occ_reg       <= count_reg;
            out_hits_reg      <= st_hits;
            out_misses_reg    <= st_misses;
            out_evictions_reg <= st_evictions;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign handle_out  = out_hdl_reg;
    assign evicted     = out_ev_reg;
    assign evicted_key = out_evk_reg;
    assign occupancy   = out_occ_reg;
    assign hits        = out_hits_reg;
    assign misses      = out_misses_reg;
    assign evictions   = out_evictions_reg;

    `LRC_ASSERT_IMPL(a_count_matches_valid, 1'b1, count_reg == CNT_W'($countones(valid_vec)))
    `LRC_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_reg == S_SCAN)
    `LRC_ASSERT_IMPL(a_evict_only_on_insert, res_ev_reg && (state_reg == S_DONE), act_reg == ACT_INSERT)

endmodule

`default_nettype wire
